// ===== src/tempo_scaled_melody_sequencer_assert.svh =====
// ============================================================================
// Assertion macros for the melody sequencer
// Concurrent checks on aclk. Define ASSERT_OFF to compile them out.
// ============================================================================
`ifndef TEMPO_SCALED_MELODY_SEQUENCER_ASSERT_SVH
`define TEMPO_SCALED_MELODY_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check outside reset
`define TSMS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("tsms assertion failed");
// Check on every edge, reset included
`define TSMS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("tsms assertion failed");
`else
`define TSMS_ASSERT(lbl, prop)
`define TSMS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== src/tsms_pkg.sv =====
// ============================================================================
// tsms_pkg
// Types, codes and constants shared by the melody sequencer modules.
// ============================================================================
package tsms_pkg;

    localparam int NOTE_DEPTH_DEF = 256;

    // Note length scale: 60000 ms per minute over 2 eighths per beat
    localparam int EIGHTH_SCALE = 30000;

    localparam int TIME_W   = 17;
    localparam int PROD_W   = 25;
    localparam int TEMPO_W  = 8;
    localparam int TICKS_W  = 16;
    localparam int FREQ_W   = 16;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Register reset values
    localparam logic [7:0]  MIN_TEMPO_RST   = 8'd60;
    localparam logic [7:0]  MAX_TEMPO_RST   = 8'd200;
    localparam logic [7:0]  TEMPO_STEP_RST  = 8'd10;
    localparam logic [7:0]  START_TEMPO_RST = 8'd120;
    localparam logic [15:0] NOTE_GAP_RST    = 16'd40;
    localparam logic [15:0] SONG_GAP_RST    = 16'd3000;
    localparam logic [15:0] REST_CODE_RST   = 16'd0;

    // Configuration register indexes
    localparam logic [2:0] CFG_MIN_TEMPO   = 3'd0;
    localparam logic [2:0] CFG_MAX_TEMPO   = 3'd1;
    localparam logic [2:0] CFG_TEMPO_STEP  = 3'd2;
    localparam logic [2:0] CFG_START_TEMPO = 3'd3;
    localparam logic [2:0] CFG_NOTE_GAP    = 3'd4;
    localparam logic [2:0] CFG_SONG_GAP    = 3'd5;
    localparam logic [2:0] CFG_REST_CODE   = 3'd6;

    // Request codes
    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_TOGGLE  = 3'd1;
    localparam logic [2:0] REQ_UP      = 3'd2;
    localparam logic [2:0] REQ_DOWN    = 3'd3;
    localparam logic [2:0] REQ_WRITE   = 3'd4;
    localparam logic [2:0] REQ_RESTART = 3'd5;

    // Phase codes
    localparam logic [1:0] PH_NOTE     = 2'd0;
    localparam logic [1:0] PH_NOTE_GAP = 2'd1;
    localparam logic [1:0] PH_SONG_GAP = 2'd2;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  note_address;
        logic [15:0] note_frequency;
        logic [7:0]  note_eighths;
        logic        note_song_end;
        logic        note_table_end;
    } req_t;

    typedef struct packed {
        logic        tone_on;
        logic [15:0] tone_frequency;
        logic [1:0]  current_phase;
        logic [7:0]  current_tempo;
        logic [7:0]  current_entry;
        logic        is_playing;
    } rsp_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [7:0]        eighths;
        logic              song_end;
        logic              table_end;
    } note_entry_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctrl_t;

    typedef struct packed {
        logic               start;
        logic [TIME_W-1:0]  mul_a;
        logic [TEMPO_W-1:0] mul_b;
        logic [TEMPO_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== src/tsms_note_mem.sv =====
// ============================================================================
// tsms_note_mem
// Single-port note table with registered read data.
// ============================================================================
module tsms_note_mem #(
    parameter int NOTE_DEPTH = tsms_pkg::NOTE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  tsms_pkg::mem_ctrl_t         ctrl,
    input  logic [$clog2(NOTE_DEPTH)-1:0] addr,
    input  tsms_pkg::note_entry_t       wdata,
    output tsms_pkg::note_entry_t       rdata
);
    import tsms_pkg::*;

    note_entry_t mem_array [NOTE_DEPTH];

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem_array[addr] <= wdata;
        end
        if (ctrl.rd_en) begin
            rdata <= mem_array[addr];
        end
    end

endmodule

// ===== src/tsms_div.sv =====
// ============================================================================
// tsms_div
// Shared multiply-then-divide unit: a product step, then restoring
// division one quotient bit per cycle.
// ============================================================================
module tsms_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  tsms_pkg::div_req_t req,
    output tsms_pkg::div_rsp_t rsp
);
    import tsms_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);
    localparam int REM_W = TEMPO_W + 1;

    typedef enum logic [1:0] {D_IDLE, D_MUL, D_DIV} dstate_t;

    dstate_t             state_reg;
    logic [TIME_W-1:0]   a_reg;
    logic [TEMPO_W-1:0]  b_reg;
    logic [TEMPO_W-1:0]  d_reg;
    logic [PROD_W-1:0]   q_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                done_reg;

    logic [REM_W-1:0]    rem_shift;
    logic                rem_ge;

    assign rem_shift = {rem_reg[TEMPO_W-1:0], q_reg[PROD_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE: begin
                    if (req.start) begin
                        a_reg     <= req.mul_a;
                        b_reg     <= req.mul_b;
                        d_reg     <= req.divisor;
                        state_reg <= D_MUL;
                    end
                end
                D_MUL: begin
                    q_reg     <= PROD_W'(a_reg) * PROD_W'(b_reg);
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= D_DIV;
                end
                D_DIV: begin
                    if (rem_ge) begin
                        rem_reg <= rem_shift - {1'b0, d_reg};
                    end else begin
                        rem_reg <= rem_shift;
                    end
                    q_reg   <= {q_reg[PROD_W-2:0], rem_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(PROD_W - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default: begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

// ===== src/tempo_scaled_melody_sequencer.sv =====
// ============================================================================
// tempo_scaled_melody_sequencer
// Tone sequencer playing a loadable note table at an adjustable tempo.
// ============================================================================
//
//  channel   ports                          direction  contents
//  -------   -----------------------------  ---------  ---------------------
//  s_        s_valid  s_ready  s_payload    in         one request (req_t)
//  m_        m_valid  m_ready  m_payload    out        one status (rsp_t)
//  cfg_      cfg_valid cfg_ready cfg_index  in         register write
//            cfg_data
//
//  Note length and tempo rescaling each run through the shared
//  multiply/divide unit, and a request that times or rescales a note
//  waits for it. A write to a table shorter than 256 entries first folds
//  the address down by NOTE_DEPTH until it fits.
//  s_ready is high only while no request is in flight; the status of the
//  last request may wait in the output register meanwhile.
//  Reset is synchronous; the note table has no reset and must be written
//  before it is played. cfg_ready is always high.
//
`include "tempo_scaled_melody_sequencer_assert.svh"

module tempo_scaled_melody_sequencer #(
    parameter int NOTE_DEPTH = tsms_pkg::NOTE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    // request channel
    input  logic            s_valid,
    output logic            s_ready,
    input  tsms_pkg::req_t  s_payload,
    // status channel
    output logic            m_valid,
    input  logic            m_ready,
    output tsms_pkg::rsp_t  m_payload,
    // configuration channel
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [15:0]     cfg_data
);
    import tsms_pkg::*;

    localparam int IDX_W = $clog2(NOTE_DEPTH);

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE, ST_EXEC, ST_ADDR, ST_RD, ST_GOT,
        ST_DIV_GO, ST_DIV_WAIT, ST_ADV, ST_FIN
    } state_t;

    // Where a table read or a division hands back to
    typedef enum logic [2:0] {
        RET_SOUND, RET_ADV, RET_NOTE_RST, RET_NOTE_ADV, RET_RESCALE
    } ret_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  min_tempo_reg;
    logic [7:0]  max_tempo_reg;
    logic [7:0]  tempo_step_reg;
    logic [7:0]  start_tempo_reg;
    logic [15:0] note_gap_reg;
    logic [15:0] song_gap_reg;
    logic [15:0] rest_code_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_tempo_reg   <= MIN_TEMPO_RST;
            max_tempo_reg   <= MAX_TEMPO_RST;
            tempo_step_reg  <= TEMPO_STEP_RST;
            start_tempo_reg <= START_TEMPO_RST;
            note_gap_reg    <= NOTE_GAP_RST;
            song_gap_reg    <= SONG_GAP_RST;
            rest_code_reg   <= REST_CODE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_TEMPO:   min_tempo_reg   <= cfg_data[7:0];
                CFG_MAX_TEMPO:   max_tempo_reg   <= cfg_data[7:0];
                CFG_TEMPO_STEP:  tempo_step_reg  <= cfg_data[7:0];
                CFG_START_TEMPO: start_tempo_reg <= cfg_data[7:0];
                CFG_NOTE_GAP:    note_gap_reg    <= cfg_data;
                CFG_SONG_GAP:    song_gap_reg    <= cfg_data;
                CFG_REST_CODE:   rest_code_reg   <= cfg_data;
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Player state
    // ------------------------------------------------------------------
    state_t              state_reg;
    ret_t                ret_reg;
    req_t                req_reg;
    logic [7:0]          addr_reg;
    logic                playing_reg;
    logic                expired_reg;
    logic [TIME_W-1:0]   time_left_reg;
    logic [TEMPO_W-1:0]  tempo_reg;
    logic [IDX_W-1:0]    entry_idx_reg;
    logic [1:0]          phase_reg;
    logic                tone_active_reg;
    logic [FREQ_W-1:0]   tone_freq_reg;
    logic                m_valid_reg;
    rsp_t                m_payload_reg;
    logic [TIME_W-1:0]   div_a_reg;
    logic [TEMPO_W-1:0]  div_b_reg;
    logic [TEMPO_W-1:0]  div_d_reg;

    // ------------------------------------------------------------------
    // Note table and shared divider
    // ------------------------------------------------------------------
    mem_ctrl_t           mem_ctrl;
    logic [IDX_W-1:0]    mem_addr;
    note_entry_t         mem_wdata;
    note_entry_t         mem_rdata;
    logic                addr_fold;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    // Address still at or beyond the table depth: fold it down once more
    assign addr_fold = 32'(addr_reg) >= 32'(NOTE_DEPTH);

    assign mem_ctrl.wr_en = (state_reg == ST_ADDR) && !addr_fold;
    assign mem_ctrl.rd_en = (state_reg == ST_RD);
    assign mem_addr       = mem_ctrl.wr_en ? IDX_W'(addr_reg) : entry_idx_reg;

    assign mem_wdata.freq      = req_reg.note_frequency;
    assign mem_wdata.eighths   = req_reg.note_eighths;
    assign mem_wdata.song_end  = req_reg.note_song_end;
    assign mem_wdata.table_end = req_reg.note_table_end;

    tsms_note_mem #(
        .NOTE_DEPTH (NOTE_DEPTH)
    ) u_note_mem (
        .aclk  (aclk),
        .ctrl  (mem_ctrl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign div_req.start   = (state_reg == ST_DIV_GO);
    assign div_req.mul_a   = div_a_reg;
    assign div_req.mul_b   = div_b_reg;
    assign div_req.divisor = div_d_reg;

    tsms_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // A zero tempo divides as one
    function automatic logic [TEMPO_W-1:0] safe_tempo(input logic [TEMPO_W-1:0] t);
        safe_tempo = (t == '0) ? TEMPO_W'(1) : t;
    endfunction

    // Clamp a quotient to the timer width
    function automatic logic [TIME_W-1:0] sat_time(input logic [PROD_W-1:0] q);
        sat_time = (q[PROD_W-1:TIME_W] != '0) ? TIME_MAX : q[TIME_W-1:0];
    endfunction

    logic [IDX_W-1:0]    entry_next;
    logic [TEMPO_W:0]    up_sum;
    logic [TEMPO_W:0]    down_limit;
    logic [TEMPO_W-1:0]  tempo_up;
    logic [TEMPO_W-1:0]  tempo_down;
    logic [TEMPO_W-1:0]  tempo_new;
    logic                rescale_ok;

    // Step to the following entry, wrapping past the last one
    assign entry_next = (entry_idx_reg == IDX_W'(NOTE_DEPTH - 1)) ? '0
                                                                  : entry_idx_reg + 1'b1;

    // Tempo steps saturate at the limits
    assign up_sum     = {1'b0, tempo_reg} + {1'b0, tempo_step_reg};
    assign tempo_up   = (up_sum <= {1'b0, max_tempo_reg}) ? up_sum[TEMPO_W-1:0]
                                                          : max_tempo_reg;
    assign down_limit = {1'b0, min_tempo_reg} + {1'b0, tempo_step_reg};
    assign tempo_down = ({1'b0, tempo_reg} >= down_limit) ? tempo_reg - tempo_step_reg
                                                          : min_tempo_reg;
    assign tempo_new  = (req_reg.req_type == REQ_UP) ? tempo_up : tempo_down;

    // Only a running, unexpired note is rescaled to the new tempo
    assign rescale_ok = (phase_reg == PH_NOTE) && (time_left_reg != '0) && !expired_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            ret_reg         <= RET_ADV;
            playing_reg     <= 1'b0;
            expired_reg     <= 1'b0;
            time_left_reg   <= '0;
            tempo_reg       <= START_TEMPO_RST;
            entry_idx_reg   <= '0;
            phase_reg       <= PH_NOTE;
            tone_active_reg <= 1'b0;
            tone_freq_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // Drop the status once it is taken, unless a new one replaces it
            if (m_valid_reg && m_ready && state_reg != ST_FIN) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_payload;
                        addr_reg  <= s_payload.note_address;
                        state_reg <= ST_EXEC;
                    end
                end

                ST_EXEC: begin
                    state_reg <= ST_ADV;
                    case (req_reg.req_type)
                        REQ_TICK: begin
                            if (playing_reg && time_left_reg != '0) begin
                                time_left_reg <= time_left_reg - 1'b1;
                                if (time_left_reg == TIME_W'(1)) begin
                                    expired_reg <= 1'b1;
                                end
                            end
                        end
                        REQ_TOGGLE: begin
                            playing_reg <= !playing_reg;
                            if (!playing_reg && phase_reg == PH_NOTE) begin
                                // Fetch the entry to sound it
                                ret_reg   <= RET_SOUND;
                                state_reg <= ST_RD;
                            end else begin
                                tone_active_reg <= 1'b0;
                            end
                        end
                        REQ_UP, REQ_DOWN: begin
                            if (tempo_new != tempo_reg) begin
                                tempo_reg <= tempo_new;
                                if (rescale_ok) begin
                                    div_a_reg <= time_left_reg;
                                    div_b_reg <= tempo_reg;
                                    div_d_reg <= safe_tempo(tempo_new);
                                    ret_reg   <= RET_RESCALE;
                                    state_reg <= ST_DIV_GO;
                                end
                            end
                        end
                        REQ_WRITE: begin
                            state_reg <= ST_ADDR;
                        end
                        REQ_RESTART: begin
                            playing_reg     <= 1'b0;
                            expired_reg     <= 1'b0;
                            tempo_reg       <= start_tempo_reg;
                            entry_idx_reg   <= '0;
                            phase_reg       <= PH_NOTE;
                            tone_active_reg <= 1'b0;
                            ret_reg         <= RET_NOTE_RST;
                            state_reg       <= ST_RD;
                        end
                        default: ;  // unknown request: only the phase advance runs
                    endcase
                end

                ST_ADDR: begin
                    // Fold the address into the table, then write
                    if (addr_fold) begin
                        addr_reg <= addr_reg - 8'(NOTE_DEPTH);
                    end else begin
                        state_reg <= ST_ADV;
                    end
                end

                ST_RD: begin
                    state_reg <= ST_GOT;
                end

                ST_GOT: begin
                    case (ret_reg)
                        RET_SOUND: begin
                            // Playing and in the note phase already checked
                            if (mem_rdata.freq != rest_code_reg) begin
                                tone_active_reg <= 1'b1;
                                tone_freq_reg   <= mem_rdata.freq;
                            end else begin
                                tone_active_reg <= 1'b0;
                            end
                            state_reg <= ST_ADV;
                        end
                        RET_ADV: begin
                            case (phase_reg)
                                PH_NOTE: begin
                                    tone_active_reg <= 1'b0;
                                    if (mem_rdata.song_end || mem_rdata.table_end) begin
                                        entry_idx_reg <= mem_rdata.table_end ? '0
                                                                              : entry_next;
                                        phase_reg     <= PH_SONG_GAP;
                                        time_left_reg <= TIME_W'(song_gap_reg);
                                        expired_reg   <= (song_gap_reg == '0);
                                    end else begin
                                        phase_reg     <= PH_NOTE_GAP;
                                        time_left_reg <= TIME_W'(note_gap_reg);
                                        expired_reg   <= (note_gap_reg == '0);
                                    end
                                    state_reg <= ST_FIN;
                                end
                                PH_NOTE_GAP: begin
                                    // Next entry: fetch it before timing it
                                    entry_idx_reg <= entry_next;
                                    phase_reg     <= PH_NOTE;
                                    ret_reg       <= RET_NOTE_ADV;
                                    state_reg     <= ST_RD;
                                end
                                default: begin
                                    // Song gap over: the entry just read starts
                                    phase_reg <= PH_NOTE;
                                    div_a_reg <= TIME_W'(EIGHTH_SCALE);
                                    div_b_reg <= mem_rdata.eighths;
                                    div_d_reg <= safe_tempo(tempo_reg);
                                    ret_reg   <= RET_NOTE_ADV;
                                    state_reg <= ST_DIV_GO;
                                end
                            endcase
                        end
                        default: begin
                            // Time a new note: scale * eighths / tempo
                            div_a_reg <= TIME_W'(EIGHTH_SCALE);
                            div_b_reg <= mem_rdata.eighths;
                            div_d_reg <= safe_tempo(tempo_reg);
                            state_reg <= ST_DIV_GO;
                        end
                    endcase
                end

                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end

                ST_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        case (ret_reg)
                            RET_RESCALE: begin
                                // Rescaled time never drops to zero
                                time_left_reg <= (div_rsp.quotient == '0)
                                               ? TIME_W'(1) : sat_time(div_rsp.quotient);
                                state_reg     <= ST_ADV;
                            end
                            RET_NOTE_ADV: begin
                                time_left_reg <= sat_time(div_rsp.quotient);
                                expired_reg   <= (div_rsp.quotient == '0);
                                if (playing_reg && mem_rdata.freq != rest_code_reg) begin
                                    tone_active_reg <= 1'b1;
                                    tone_freq_reg   <= mem_rdata.freq;
                                end else begin
                                    tone_active_reg <= 1'b0;
                                end
                                state_reg <= ST_FIN;
                            end
                            default: begin
                                time_left_reg <= sat_time(div_rsp.quotient);
                                expired_reg   <= (div_rsp.quotient == '0);
                                state_reg     <= ST_ADV;
                            end
                        endcase
                    end
                end

                ST_ADV: begin
                    // Advance the phase once if its time ran out
                    if (expired_reg) begin
                        expired_reg <= 1'b0;
                        ret_reg     <= RET_ADV;
                        state_reg   <= ST_RD;
                    end else begin
                        state_reg <= ST_FIN;
                    end
                end

                ST_FIN: begin
                    // Hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_payload_reg.tone_on        <= tone_active_reg;
                        m_payload_reg.tone_frequency <= tone_active_reg ? tone_freq_reg
                                                                        : '0;
                        m_payload_reg.current_phase  <= phase_reg;
                        m_payload_reg.current_tempo  <= tempo_reg;
                        m_payload_reg.current_entry  <= 8'(entry_idx_reg);
                        m_payload_reg.is_playing     <= playing_reg;
                        m_valid_reg                  <= 1'b1;
                        state_reg                    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A sounding tone belongs to a playing note phase
    `TSMS_ASSERT(a_tone_in_note, tone_active_reg |-> (playing_reg && phase_reg == PH_NOTE))
    // Between requests an expired phase has no time left
    `TSMS_ASSERT(a_expired_zero, (state_reg == ST_IDLE && expired_reg) |-> (time_left_reg == '0))
    // An accepted request always leaves idle
    `TSMS_ASSERT(a_accept_busy, (s_valid && s_ready) |=> (state_reg != ST_IDLE))
    // Reset empties the output register
    `TSMS_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> !m_valid)

endmodule
